// ===== sv/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types and constants for the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5b;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5d;
    localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7b;
    localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7d;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_MISMATCH = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } t_err;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_kind kind;
        logic  last;
    } t_op;

endpackage

// ===== sv/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bbc_front.sv =====
// ----------------------------------------------------------------------------
// bbc_front
// accepts character beats, decodes bracket kind and registers the op
// ----------------------------------------------------------------------------
module bbc_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [7:0]   i_char_in,
    input  logic         i_is_last,
    output logic         o_op_valid,
    output bbc_pkg::t_op o_op,
    input  logic         i_q_full
);

    logic         r_valid;
    logic         n_valid;
    bbc_pkg::t_op r_op;
    bbc_pkg::t_op n_op;
    logic         w_accept;
    logic         w_push;

    always_comb begin
        n_op          = '0;
        n_op.last     = i_is_last;
        n_op.kind     = bbc_pkg::KIND_ROUND;
        unique case (i_char_in)
            bbc_pkg::CHAR_OPEN_ROUND: begin
                n_op.is_open = 1'b1;
            end
            bbc_pkg::CHAR_OPEN_SQUARE: begin
                n_op.is_open = 1'b1;
                n_op.kind    = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CHAR_OPEN_CURLY: begin
                n_op.is_open = 1'b1;
                n_op.kind    = bbc_pkg::KIND_CURLY;
            end
            bbc_pkg::CHAR_CLOSE_ROUND: begin
                n_op.is_close = 1'b1;
            end
            bbc_pkg::CHAR_CLOSE_SQUARE: begin
                n_op.is_close = 1'b1;
                n_op.kind     = bbc_pkg::KIND_SQUARE;
            end
            bbc_pkg::CHAR_CLOSE_CURLY: begin
                n_op.is_close = 1'b1;
                n_op.kind     = bbc_pkg::KIND_CURLY;
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall = r_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_push     = r_valid && !i_q_full;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= n_op;
        end
    end

    assign o_op_valid = r_valid;
    assign o_op       = r_op;

endmodule

// ===== sv/bbc_queue.sv =====
// ----------------------------------------------------------------------------
// bbc_queue
// two-entry fifo of decoded ops between front and back
// ----------------------------------------------------------------------------
module bbc_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  bbc_pkg::t_op i_op,
    output logic         o_full,
    output logic         o_valid,
    output bbc_pkg::t_op o_op,
    input  logic         i_pop
);

    bbc_pkg::t_op r_ent [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic [1:0]   n_count;
    logic         w_wr;
    logic         w_rd;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_op    = r_ent[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ent[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== sv/bbc_back.sv =====
// ----------------------------------------------------------------------------
// bbc_back
// bracket stack with top register and prefetched second entry, verdict output
// ----------------------------------------------------------------------------
module bbc_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_valid,
    input  bbc_pkg::t_op i_op,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_balanced,
    output logic [2:0]   o_error_code
);

    logic [bbc_pkg::DEPTH_W-1:0] r_depth;
    logic [bbc_pkg::DEPTH_W-1:0] n_depth;
    logic [bbc_pkg::DEPTH_W-1:0] w_rd_idx;
    bbc_pkg::t_kind              r_top;
    bbc_pkg::t_kind              n_top;
    bbc_pkg::t_err               r_err;
    bbc_pkg::t_err               n_err;
    bbc_pkg::t_err               w_code;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        r_balanced;
    bbc_pkg::t_err               r_code;
    logic                        w_can_out;
    logic                        w_take;
    logic                        w_we;
    logic [bbc_pkg::ADDR_W-1:0]  w_waddr;
    logic [bbc_pkg::ADDR_W-1:0]  w_raddr;
    logic [1:0]                  w_second;

    assign w_can_out = !r_out_valid || !i_out_stall;
    assign w_take    = i_op_valid && (!i_op.last || w_can_out);
    assign o_pop     = w_take;

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        n_err   = r_err;
        w_we    = 1'b0;
        w_waddr = r_depth[bbc_pkg::ADDR_W-1:0];
        w_code  = bbc_pkg::ERR_OK;
        if (w_take && r_err == bbc_pkg::ERR_OK) begin
            if (i_op.is_open) begin
                if (r_depth == bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH)) begin
                    n_err = bbc_pkg::ERR_OVERFLOW;
                end else begin
                    w_we    = 1'b1;
                    n_top   = i_op.kind;
                    n_depth = r_depth + bbc_pkg::DEPTH_W'(1);
                end
            end else if (i_op.is_close) begin
                if (r_depth == '0) begin
                    n_err = bbc_pkg::ERR_EMPTY;
                end else if (r_top != i_op.kind) begin
                    n_err = bbc_pkg::ERR_MISMATCH;
                end else begin
                    n_depth = r_depth - bbc_pkg::DEPTH_W'(1);
                    n_top   = bbc_pkg::t_kind'(w_second);
                end
            end
        end
        if (w_take && i_op.last) begin
            if (n_err != bbc_pkg::ERR_OK) begin
                w_code = n_err;
            end else if (n_depth != '0) begin
                w_code = bbc_pkg::ERR_UNCLOSED;
            end
            n_depth = '0;
            n_err   = bbc_pkg::ERR_OK;
        end
    end

    // prefetch the entry just below the next top
    assign w_rd_idx = n_depth - bbc_pkg::DEPTH_W'(2);
    assign w_raddr  = w_rd_idx[bbc_pkg::ADDR_W-1:0];

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (bbc_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_op.kind),
        .i_raddr (w_raddr),
        .o_rdata (w_second)
    );

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_take && i_op.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_err       <= bbc_pkg::ERR_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (w_take && i_op.last) begin
            r_code     <= w_code;
            r_balanced <= w_code == bbc_pkg::ERR_OK;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_balanced   = r_balanced;
    assign o_error_code = r_code;

endmodule

// ===== sv/bracket_balance_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_balance_checker
// checks round, square and curly bracket nesting of a byte stream and gives
// one verdict beat per expression on the beat flagged last
// ----------------------------------------------------------------------------
// path: last beat passes the front register and the queue into the verdict register
// throughput: one beat per cycle unless stalled, set by one push or pop a cycle on
//   the top register with the entry below it prefetched from the stack ram
// reset: control state cleared, stack ram contents left undefined, no clearing pass
module bracket_balance_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_balanced,
    output logic [2:0] o_error_code
);

    logic         w_f_valid;
    bbc_pkg::t_op w_f_op;
    logic         w_q_full;
    logic         w_q_valid;
    bbc_pkg::t_op w_q_op;
    logic         w_q_pop;

    bbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_char_in  (i_char_in),
        .i_is_last  (i_is_last),
        .o_op_valid (w_f_valid),
        .o_op       (w_f_op),
        .i_q_full   (w_q_full)
    );

    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_op    (w_f_op),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_pop   (w_q_pop)
    );

    bbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (w_q_valid),
        .i_op         (w_q_op),
        .o_pop        (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_balanced   (o_balanced),
        .o_error_code (o_error_code)
    );

endmodule
